[sv/rft_pkg.sv]
// Package for the radio frequency tuner: payload types, action codes and constants.
`default_nettype none

package rft_pkg;

    localparam int MhzWidth = 8;
    localparam int KhzWidth = 10;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 8;

    localparam logic [KhzWidth-1:0] KhzPerMhz = 10'd1000;
    localparam logic [KhzWidth-1:0] KhzMax = 10'd999;
    localparam logic [KhzWidth-1:0] SpacingNarrow = 10'd25;
    localparam logic [KhzWidth-1:0] SpacingWide = 10'd50;

    localparam logic [MhzWidth-1:0] ResetBandLow = 8'd118;
    localparam logic [MhzWidth-1:0] ResetBandHigh = 8'd136;
    localparam logic [MhzWidth-1:0] ResetMhz = 8'd122;
    localparam logic [KhzWidth-1:0] ResetKhz = 10'd100;

    // floor(k * Recip25 / 2^Recip25Shift) equals floor(k / 25) for all k up to 999.
    localparam int Recip25Shift = 15;
    localparam logic [10:0] Recip25 = 11'd1311;

    typedef enum logic [2:0] {
        ACT_TUNE_UP     = 3'd0,
        ACT_TUNE_DOWN   = 3'd1,
        ACT_SWAP        = 3'd2,
        ACT_TOGGLE      = 3'd3,
        ACT_SET_ACTIVE  = 3'd4,
        ACT_SET_STANDBY = 3'd5
    } action_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SPACING   = 2'd0,
        CFG_BAND_LOW  = 2'd1,
        CFG_BAND_HIGH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]          action;
        logic [MhzWidth-1:0] load_mhz;
        logic [KhzWidth-1:0] load_khz;
    } rft_in_t;

    typedef struct packed {
        logic [MhzWidth-1:0] active_mhz;
        logic [KhzWidth-1:0] active_khz;
        logic [MhzWidth-1:0] standby_mhz_out;
        logic [KhzWidth-1:0] standby_khz_out;
        logic                coarse_out;
    } rft_out_t;

endpackage

`default_nettype wire

[sv/radio_frequency_tuner_core.sv]
// Radio frequency tuner: active and standby frequency registers with tuning actions.
//
// Input beats arrive on in_valid/in_stall with in_data; each beat carries one
// action. Every accepted beat produces exactly one result beat on
// out_valid/out_stall reporting the active and standby frequencies and the
// coarse flag after the action. A beat is captured in an input register, the
// action is applied to the state as the beat moves on and the result lands in
// an output register that drives out_valid. One beat per cycle is sustained
// while the receiver does not stall; the state update is a single pass of
// adds and compares on 8- and 10-bit values plus a constant-reciprocal multiply
// for kHz truncation. While the receiver stalls, the output register holds its
// beat and one more beat waits in the input register, after which in_stall
// rises. Reset sets both frequencies to 122.100 MHz in fine mode, 25 kHz spacing
// and a band of 118 to 136 MHz. Configuration writes on cfg_write, cfg_index
// and cfg_data take effect at once and are meant for idle periods.
`default_nettype none

module radio_frequency_tuner_core
    import rft_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire rft_in_t                  in_data,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output rft_out_t                      out_data,
    input  wire logic                     cfg_write,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

    logic                spacing_is_fifty_reg;
    logic [MhzWidth-1:0] band_low_reg;
    logic [MhzWidth-1:0] band_high_reg;

    logic [MhzWidth-1:0] active_mhz_reg, active_mhz_next;
    logic [KhzWidth-1:0] active_khz_reg, active_khz_next;
    logic [MhzWidth-1:0] standby_mhz_reg, standby_mhz_next;
    logic [KhzWidth-1:0] standby_khz_reg, standby_khz_next;
    logic                coarse_reg, coarse_next;

    logic     in_valid_reg;
    rft_in_t  in_data_reg;
    logic     out_valid_reg;
    rft_out_t out_data_reg;
    logic     advance;

    logic [KhzWidth-1:0] spacing;
    logic [KhzWidth-1:0] load_sat;
    logic [20:0]         recip_prod;
    logic [5:0]          quot25;
    logic [KhzWidth-1:0] load_trunc;
    logic [KhzWidth:0]   khz_sum;
    logic [MhzWidth-1:0] mhz_step;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_is_fifty_reg <= 1'b0;
            band_low_reg         <= ResetBandLow;
            band_high_reg        <= ResetBandHigh;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SPACING:   spacing_is_fifty_reg <= cfg_data[0];
                CFG_BAND_LOW:  band_low_reg         <= cfg_data;
                CFG_BAND_HIGH: band_high_reg        <= cfg_data;
                default:       ;
            endcase
        end
    end

    // kHz truncation for the set actions: divide by 25 through a reciprocal,
    // halve for 50 kHz spacing, then scale back up.
    always_comb
    begin
        spacing    = spacing_is_fifty_reg ? SpacingWide : SpacingNarrow;
        load_sat   = (in_data_reg.load_khz > KhzMax) ? KhzMax : in_data_reg.load_khz;
        recip_prod = 21'(load_sat) * 21'(Recip25);
        quot25     = recip_prod[Recip25Shift +: 6];
        if (spacing_is_fifty_reg)
            load_trunc = KhzWidth'({1'b0, quot25[5:1]}) * SpacingWide;
        else
            load_trunc = KhzWidth'(quot25) * SpacingNarrow;
    end

    always_comb
    begin
        active_mhz_next  = active_mhz_reg;
        active_khz_next  = active_khz_reg;
        standby_mhz_next = standby_mhz_reg;
        standby_khz_next = standby_khz_reg;
        coarse_next      = coarse_reg;
        khz_sum          = {1'b0, standby_khz_reg} + {1'b0, spacing};
        mhz_step         = standby_mhz_reg;

        unique case (in_data_reg.action)
            ACT_TUNE_UP:
            begin
                if (coarse_reg)
                    mhz_step = standby_mhz_reg + 8'd1;
                else if (khz_sum >= {1'b0, KhzPerMhz})
                begin
                    standby_khz_next = '0;
                    mhz_step         = standby_mhz_reg + 8'd1;
                end
                else
                    standby_khz_next = khz_sum[KhzWidth-1:0];
                standby_mhz_next = (mhz_step > band_high_reg) ? band_low_reg : mhz_step;
            end
            ACT_TUNE_DOWN:
            begin
                if (coarse_reg)
                    mhz_step = standby_mhz_reg - 8'd1;
                else if (standby_khz_reg >= spacing)
                    standby_khz_next = standby_khz_reg - spacing;
                else
                begin
                    standby_khz_next = KhzPerMhz - spacing;
                    mhz_step         = standby_mhz_reg - 8'd1;
                end
                standby_mhz_next = (mhz_step < band_low_reg) ? band_high_reg : mhz_step;
            end
            ACT_SWAP:
            begin
                active_mhz_next  = standby_mhz_reg;
                active_khz_next  = standby_khz_reg;
                standby_mhz_next = active_mhz_reg;
                standby_khz_next = active_khz_reg;
            end
            ACT_TOGGLE:
                coarse_next = !coarse_reg;
            ACT_SET_ACTIVE:
            begin
                active_mhz_next = in_data_reg.load_mhz;
                active_khz_next = load_trunc;
            end
            ACT_SET_STANDBY:
            begin
                standby_mhz_next = in_data_reg.load_mhz;
                standby_khz_next = load_trunc;
            end
            default: ;
        endcase
    end

    // Tuner state, updated once per beat as it moves to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mhz_reg  <= ResetMhz;
            active_khz_reg  <= ResetKhz;
            standby_mhz_reg <= ResetMhz;
            standby_khz_reg <= ResetKhz;
            coarse_reg      <= 1'b0;
        end
        else if (advance)
        begin
            active_mhz_reg  <= active_mhz_next;
            active_khz_reg  <= active_khz_next;
            standby_mhz_reg <= standby_mhz_next;
            standby_khz_reg <= standby_khz_next;
            coarse_reg      <= coarse_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg.active_mhz      <= active_mhz_next;
            out_data_reg.active_khz      <= active_khz_next;
            out_data_reg.standby_mhz_out <= standby_mhz_next;
            out_data_reg.standby_khz_out <= standby_khz_next;
            out_data_reg.coarse_out      <= coarse_next;
        end
    end

endmodule

`default_nettype wire

[tb/radio_frequency_tuner_core_tb.sv]
// Self-checking testbench for the radio frequency tuner core with randomized handshakes.
module radio_frequency_tuner_core_tb;
    import rft_pkg::*;

    localparam int CyclesLimit = 300000;
    localparam int SettleCycles = 4;
    localparam int MaxGap = 12;
    localparam int ReportLimit = 10;
    localparam int NumPhases = 7;
    localparam int PhaseItems = 80;

    // Action codes the block treats as no-ops.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    class tuner_tracker;
        logic                wide_spacing;
        logic [MhzWidth-1:0] band_low;
        logic [MhzWidth-1:0] band_high;
        logic [MhzWidth-1:0] act_mhz;
        logic [KhzWidth-1:0] act_khz;
        logic [MhzWidth-1:0] sby_mhz;
        logic [KhzWidth-1:0] sby_khz;
        logic                coarse;
        rft_out_t            expected_readouts[$];
        int                  mismatches;

        function void restore_reset();
            wide_spacing = 1'b0;
            band_low = ResetBandLow;
            band_high = ResetBandHigh;
            act_mhz = ResetMhz;
            act_khz = ResetKhz;
            sby_mhz = ResetMhz;
            sby_khz = ResetKhz;
            coarse = 1'b0;
            expected_readouts.delete();
            mismatches = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CfgDataWidth-1:0] value);
            case (idx)
                CFG_SPACING:   wide_spacing = value[0];
                CFG_BAND_LOW:  band_low = value;
                CFG_BAND_HIGH: band_high = value;
                default: ;
            endcase
        endfunction

        function int spacing();
            return wide_spacing ? int'(SpacingWide) : int'(SpacingNarrow);
        endfunction

        function logic [KhzWidth-1:0] snap_khz(logic [KhzWidth-1:0] khz);
            int k;
            int s;
            s = spacing();
            k = (khz > KhzMax) ? int'(KhzMax) : int'(khz);
            return KhzWidth'((k / s) * s);
        endfunction

        function void note_command(rft_in_t cmd);
            int                  k;
            logic [MhzWidth-1:0] t_mhz;
            logic [KhzWidth-1:0] t_khz;
            rft_out_t            r;
            case (cmd.action)
                ACT_TUNE_UP:
                begin
                    if (coarse)
                        sby_mhz = sby_mhz + 8'd1;
                    else
                    begin
                        k = int'(sby_khz) + spacing();
                        if (k >= int'(KhzPerMhz))
                        begin
                            sby_khz = '0;
                            sby_mhz = sby_mhz + 8'd1;
                        end
                        else
                            sby_khz = KhzWidth'(k);
                    end
                    if (sby_mhz > band_high)
                        sby_mhz = band_low;
                end
                ACT_TUNE_DOWN:
                begin
                    if (coarse)
                        sby_mhz = sby_mhz - 8'd1;
                    else if (int'(sby_khz) >= spacing())
                        sby_khz = KhzWidth'(int'(sby_khz) - spacing());
                    else
                    begin
                        // Borrow lands on the last channel below the MHz boundary.
                        sby_khz = KhzWidth'(int'(KhzPerMhz) - spacing());
                        sby_mhz = sby_mhz - 8'd1;
                    end
                    if (sby_mhz < band_low)
                        sby_mhz = band_high;
                end
                ACT_SWAP:
                begin
                    t_mhz = act_mhz;
                    act_mhz = sby_mhz;
                    sby_mhz = t_mhz;
                    t_khz = act_khz;
                    act_khz = sby_khz;
                    sby_khz = t_khz;
                end
                ACT_TOGGLE:
                    coarse = ~coarse;
                ACT_SET_ACTIVE:
                begin
                    act_mhz = cmd.load_mhz;
                    act_khz = snap_khz(cmd.load_khz);
                end
                ACT_SET_STANDBY:
                begin
                    sby_mhz = cmd.load_mhz;
                    sby_khz = snap_khz(cmd.load_khz);
                end
                default: ;
            endcase
            r.active_mhz = act_mhz;
            r.active_khz = act_khz;
            r.standby_mhz_out = sby_mhz;
            r.standby_khz_out = sby_khz;
            r.coarse_out = coarse;
            expected_readouts.push_back(r);
        endfunction

        function void check_readout(rft_out_t got);
            rft_out_t want;
            logic     bad;
            if (expected_readouts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("Unexpected result beat: active %0d.%0d standby %0d.%0d coarse %0d",
                             got.active_mhz, got.active_khz, got.standby_mhz_out,
                             got.standby_khz_out, got.coarse_out);
                return;
            end
            want = expected_readouts.pop_front();
            bad = (got.active_mhz !== want.active_mhz) || (got.active_khz !== want.active_khz)
                || (got.standby_mhz_out !== want.standby_mhz_out)
                || (got.standby_khz_out !== want.standby_khz_out)
                || (got.coarse_out !== want.coarse_out);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= ReportLimit)
                begin
                    $display("Mismatch: expected active %0d.%0d standby %0d.%0d coarse %0d,",
                             want.active_mhz, want.active_khz, want.standby_mhz_out,
                             want.standby_khz_out, want.coarse_out);
                    $display("          got active %0d.%0d standby %0d.%0d coarse %0d",
                             got.active_mhz, got.active_khz, got.standby_mhz_out,
                             got.standby_khz_out, got.coarse_out);
                end
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid;
    logic                     in_stall;
    rft_in_t                  in_data;
    logic                     out_valid;
    logic                     out_stall;
    rft_out_t                 out_data;
    logic                     cfg_write;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    tuner_tracker tracker;
    int           cycle_count = 0;
    bit           send_calm = 1'b0;
    int           run_left = 0;
    logic [2:0]   run_action = ACT_TUNE_UP;

    int phase_spacing [NumPhases] = '{1, 0, 1, 0, 1, 0, 1};
    int phase_low     [NumPhases] = '{118, 0, 255, 100, 0, 200, 255};
    int phase_high    [NumPhases] = '{136, 255, 0, 102, 0, 210, 255};

    radio_frequency_tuner_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CyclesLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic rft_in_t make_cmd(logic [2:0] act, logic [MhzWidth-1:0] mhz,
                                         logic [KhzWidth-1:0] khz);
        rft_in_t c;
        c.action = act;
        c.load_mhz = mhz;
        c.load_khz = khz;
        return c;
    endfunction

    // Loads mostly land near the band edges so that later tuning crosses the wraps.
    function automatic logic [MhzWidth-1:0] pick_mhz();
        int base;
        if ($urandom_range(0, 3) == 0)
            return MhzWidth'($urandom_range(0, 255));
        base = $urandom_range(0, 1) ? int'(tracker.band_low) : int'(tracker.band_high);
        return MhzWidth'(base + int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic [KhzWidth-1:0] pick_khz();
        case ($urandom_range(0, 3))
            0: return KhzWidth'($urandom_range(0, 1023));
            1: return KhzWidth'($urandom_range(0, 60));
            2: return KhzWidth'($urandom_range(940, 1023));
            default: return KhzWidth'($urandom_range(0, 999));
        endcase
    endfunction

    function automatic rft_in_t random_cmd();
        int         w;
        logic [2:0] act;
        if (run_left > 0)
        begin
            run_left--;
            return make_cmd(run_action, pick_mhz(), pick_khz());
        end
        // Long runs of one tuning direction walk across MHz boundaries and band edges.
        if ($urandom_range(0, 99) < 12)
        begin
            run_action = $urandom_range(0, 1) ? ACT_TUNE_UP : ACT_TUNE_DOWN;
            run_left = $urandom_range(5, 40);
        end
        w = $urandom_range(0, 99);
        if (w < 30)
            act = ACT_TUNE_UP;
        else if (w < 60)
            act = ACT_TUNE_DOWN;
        else if (w < 68)
            act = ACT_SWAP;
        else if (w < 76)
            act = ACT_TOGGLE;
        else if (w < 84)
            act = ACT_SET_ACTIVE;
        else if (w < 96)
            act = ACT_SET_STANDBY;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        return make_cmd(act, pick_mhz(), pick_khz());
    endfunction

    // Called and returns at a falling edge.
    task automatic send_command(rft_in_t cmd);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= cmd;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_command(cmd);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.expected_readouts.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic program_tuner(logic spacing50, logic [MhzWidth-1:0] low,
                                 logic [MhzWidth-1:0] high);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SPACING;
        cfg_data <= {7'd0, spacing50};
        @(negedge clk);
        cfg_index <= CFG_BAND_LOW;
        cfg_data <= low;
        @(negedge clk);
        cfg_index <= CFG_BAND_HIGH;
        cfg_data <= high;
        @(negedge clk);
        cfg_write <= 1'b0;
        tracker.set_register(CFG_SPACING, {7'd0, spacing50});
        tracker.set_register(CFG_BAND_LOW, low);
        tracker.set_register(CFG_BAND_HIGH, high);
    endtask

    initial
    begin : result_sink
        int hold;
        bit calm;
        out_stall = 1'b0;
        calm = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            hold = calm ? 0 : $urandom_range(0, MaxGap);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            tracker.check_readout(out_data);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_SPACING;
        cfg_data = '0;
        tracker = new;
        tracker.restore_reset();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        program_tuner(1'b0, ResetBandLow, ResetBandHigh);

        send_command(make_cmd(ACT_TUNE_UP, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TUNE_DOWN, 8'd0, 10'd0));
        // Fine carry past the top of the band, then a borrow below the bottom.
        send_command(make_cmd(ACT_SET_STANDBY, 8'd136, 10'd975));
        send_command(make_cmd(ACT_TUNE_UP, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TUNE_DOWN, 8'd0, 10'd0));
        // Load kHz above 999 saturates before truncation.
        send_command(make_cmd(ACT_SET_STANDBY, 8'd255, 10'd1023));
        send_command(make_cmd(ACT_SET_ACTIVE, 8'd0, 10'd24));
        send_command(make_cmd(ACT_SET_ACTIVE, 8'd255, 10'd999));
        send_command(make_cmd(ACT_SWAP, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TOGGLE, 8'd0, 10'd0));
        // Coarse steps: MHz wraps through 255 and 0 before the band compare.
        send_command(make_cmd(ACT_TUNE_UP, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TUNE_DOWN, 8'd0, 10'd0));
        send_command(make_cmd(ACT_SET_STANDBY, 8'd118, 10'd0));
        send_command(make_cmd(ACT_TUNE_DOWN, 8'd0, 10'd0));
        send_command(make_cmd(ACT_SET_STANDBY, 8'd136, 10'd500));
        send_command(make_cmd(ACT_TUNE_UP, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TOGGLE, 8'd0, 10'd0));
        send_command(make_cmd(ACT_SPARE_6, 8'd255, 10'd1023));
        send_command(make_cmd(ACT_SPARE_7, 8'd0, 10'd0));
        send_command(make_cmd(ACT_SET_STANDBY, 8'd0, 10'd0));
        send_command(make_cmd(ACT_TUNE_DOWN, 8'd0, 10'd0));
        send_command(make_cmd(ACT_SET_ACTIVE, 8'd1, 10'd1000));
        send_command(make_cmd(ACT_SWAP, 8'd0, 10'd0));
        wait_quiet();

        // Each phase changes the spacing and band; stored kHz values are kept as they are.
        for (int p = 0; p < NumPhases; p++)
        begin
            program_tuner(phase_spacing[p][0], MhzWidth'(phase_low[p]),
                          MhzWidth'(phase_high[p]));
            run_left = 0;
            for (int i = 0; i < PhaseItems; i++)
                send_command(random_cmd());
            wait_quiet();
        end

        if (tracker.mismatches == 0 && tracker.expected_readouts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[radio_frequency_tuner_core.f]
sv/rft_pkg.sv
sv/radio_frequency_tuner_core.sv
tb/radio_frequency_tuner_core_tb.sv
